[sv/idnsc_pkg.sv]
// Package for the IDN label script safety checker.
// Holds widths of the property fields, fail reasons, the script combination
// table and the registered item type. No dependencies.
package idnsc_pkg;

  localparam int unsigned CP_W     = 21;
  localparam int unsigned SCRIPT_W = 8;
  localparam int unsigned GROUP_W  = 4;
  localparam int unsigned CLASS_W  = 2;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned HAN_W    = 2;
  localparam int unsigned REASON_W = 3;
  localparam int unsigned PROF_W   = 2;
  localparam int unsigned COMBO_W  = 4;

  // Restriction profiles
  localparam logic [PROF_W-1:0] PROF_ASCII    = 2'd0;
  localparam logic [PROF_W-1:0] PROF_MODERATE = 2'd1;
  localparam logic [PROF_W-1:0] PROF_HIGH     = 2'd2;
  localparam logic [PROF_W-1:0] PROF_RESERVED = 2'd3;

  // Identifier restriction classes
  localparam logic [CLASS_W-1:0] XID_RECOMMENDED = 2'd0;
  localparam logic [CLASS_W-1:0] XID_LIMITED     = 2'd1;

  // Script groups
  localparam logic [GROUP_W-1:0] GRP_LATIN     = 4'd7;
  localparam logic [GROUP_W-1:0] GRP_COMMON    = 4'd9;
  localparam logic [GROUP_W-1:0] GRP_INHERITED = 4'd10;

  // Han variants
  localparam logic [HAN_W-1:0] HAN_NONE        = 2'd0;
  localparam logic [HAN_W-1:0] HAN_SIMPLIFIED  = 2'd1;
  localparam logic [HAN_W-1:0] HAN_TRADITIONAL = 2'd2;

  // Fail reasons
  localparam logic [REASON_W-1:0] FAIL_NONE     = 3'd0;
  localparam logic [REASON_W-1:0] FAIL_ASCII    = 3'd1;
  localparam logic [REASON_W-1:0] FAIL_XID      = 3'd2;
  localparam logic [REASON_W-1:0] FAIL_SCRIPT   = 3'd3;
  localparam logic [REASON_W-1:0] FAIL_NUMBERS  = 3'd4;
  localparam logic [REASON_W-1:0] FAIL_MARK     = 3'd5;
  localparam logic [REASON_W-1:0] FAIL_HAN      = 3'd6;

  // Combination states: single scripts 0..8, then jpan, chna, kore, hnlt, fail
  localparam logic [COMBO_W-1:0] ST_BOPO  = 4'd0;
  localparam logic [COMBO_W-1:0] ST_CYRL  = 4'd1;
  localparam logic [COMBO_W-1:0] ST_GREK  = 4'd2;
  localparam logic [COMBO_W-1:0] ST_HANG  = 4'd3;
  localparam logic [COMBO_W-1:0] ST_HANI  = 4'd4;
  localparam logic [COMBO_W-1:0] ST_HIRA  = 4'd5;
  localparam logic [COMBO_W-1:0] ST_KANA  = 4'd6;
  localparam logic [COMBO_W-1:0] ST_LATN  = 4'd7;
  localparam logic [COMBO_W-1:0] ST_OTHER = 4'd8;
  localparam logic [COMBO_W-1:0] ST_JPAN  = 4'd9;
  localparam logic [COMBO_W-1:0] ST_CHNA  = 4'd10;
  localparam logic [COMBO_W-1:0] ST_KORE  = 4'd11;
  localparam logic [COMBO_W-1:0] ST_HNLT  = 4'd12;
  localparam logic [COMBO_W-1:0] ST_FAIL  = 4'd13;
  localparam logic [COMBO_W-1:0] COL_OTHER = 4'd8;

  localparam int unsigned COMBO_ROWS = 13;
  localparam int unsigned COMBO_COLS = 9;

  localparam logic [COMBO_W-1:0] COMBO_TABLE [COMBO_ROWS][COMBO_COLS] = '{
    '{ST_BOPO, ST_FAIL, ST_FAIL, ST_FAIL, ST_CHNA, ST_FAIL, ST_FAIL, ST_CHNA, ST_FAIL},
    '{ST_FAIL, ST_CYRL, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL},
    '{ST_FAIL, ST_FAIL, ST_GREK, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL},
    '{ST_FAIL, ST_FAIL, ST_FAIL, ST_HANG, ST_KORE, ST_FAIL, ST_FAIL, ST_KORE, ST_FAIL},
    '{ST_CHNA, ST_FAIL, ST_FAIL, ST_KORE, ST_HANI, ST_JPAN, ST_JPAN, ST_HNLT, ST_FAIL},
    '{ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_JPAN, ST_HIRA, ST_JPAN, ST_JPAN, ST_FAIL},
    '{ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_JPAN, ST_JPAN, ST_KANA, ST_JPAN, ST_FAIL},
    '{ST_CHNA, ST_FAIL, ST_FAIL, ST_KORE, ST_HNLT, ST_JPAN, ST_JPAN, ST_LATN, ST_OTHER},
    '{ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_OTHER, ST_FAIL},
    '{ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_JPAN, ST_JPAN, ST_JPAN, ST_JPAN, ST_FAIL},
    '{ST_CHNA, ST_FAIL, ST_FAIL, ST_FAIL, ST_CHNA, ST_FAIL, ST_FAIL, ST_CHNA, ST_FAIL},
    '{ST_FAIL, ST_FAIL, ST_FAIL, ST_KORE, ST_KORE, ST_FAIL, ST_FAIL, ST_KORE, ST_FAIL},
    '{ST_CHNA, ST_FAIL, ST_FAIL, ST_KORE, ST_HNLT, ST_JPAN, ST_JPAN, ST_HNLT, ST_FAIL}
  };

  // Next combination state; the fail state and anything beyond, or a column beyond other, stay failed
  function automatic logic [COMBO_W-1:0] combo_step(input logic [COMBO_W-1:0] st,
                                                    input logic [COMBO_W-1:0] col);
    logic [COMBO_W-1:0] res;
    begin
      if (st < ST_FAIL && col <= COL_OTHER) begin
        res = COMBO_TABLE[st][col];
      end else begin
        res = ST_FAIL;
      end
      return res;
    end
  endfunction

  typedef struct packed {
    logic [CP_W-1:0]     code_point;
    logic [SCRIPT_W-1:0] script_code;
    logic [GROUP_W-1:0]  script_group;
    logic [CLASS_W-1:0]  xid_class;
    logic                exempt_script;
    logic                is_decimal_digit;
    logic [DIGIT_W-1:0]  digit_value;
    logic                is_nonspacing_mark;
    logic [HAN_W-1:0]    han_variant;
    logic                first_in_label;
    logic                last_in_label;
  } item_t;

endpackage

[sv/idnsc_if.sv]
// Channel interfaces of the IDN label script safety checker: characters in,
// verdicts out, profile writes. Depend on idnsc_pkg for field widths.
interface idnsc_item_if import idnsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CP_W-1:0]     code_point;
  logic [SCRIPT_W-1:0] script_code;
  logic [GROUP_W-1:0]  script_group;
  logic [CLASS_W-1:0]  xid_class;
  logic                exempt_script;
  logic                is_decimal_digit;
  logic [DIGIT_W-1:0]  digit_value;
  logic                is_nonspacing_mark;
  logic [HAN_W-1:0]    han_variant;
  logic                first_in_label;
  logic                last_in_label;

  modport source (
    output valid, code_point, script_code, script_group, xid_class, exempt_script,
           is_decimal_digit, digit_value, is_nonspacing_mark, han_variant,
           first_in_label, last_in_label,
    input  ready
  );
  modport sink (
    input  valid, code_point, script_code, script_group, xid_class, exempt_script,
           is_decimal_digit, digit_value, is_nonspacing_mark, han_variant,
           first_in_label, last_in_label,
    output ready
  );
endinterface

interface idnsc_verdict_if import idnsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                label_safe;
  logic [REASON_W-1:0] fail_reason;

  modport source (output valid, label_safe, fail_reason, input ready);
  modport sink (input valid, label_safe, fail_reason, output ready);
endinterface

interface idnsc_cfg_if import idnsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PROF_W-1:0] profile_sel;

  modport source (output valid, profile_sel, input ready);
  modport sink (input valid, profile_sel, output ready);
endinterface

[sv/idn_label_script_safety_check.sv]
// IDN label script safety checker, top level.
// Depends on idnsc_pkg and the channel interfaces in idnsc_if.sv.
//
// Usage:
//   items    : one request per character of a label, with its looked-up Unicode
//              properties. first_in_label starts a fresh label, last_in_label
//              asks for the verdict.
//   verdicts : one request per label, issued for the character that carries
//              last_in_label: label_safe and fail_reason.
//   cfg      : writes profile_sel; always ready. Write it only while
//              no label is in flight.
// Timing: a character is registered on acceptance and checked in the next
//   cycle; its verdict is loaded into the output register once it advances,
//   which raises verdicts.valid. One character per cycle is sustained unless a
//   last_in_label character waits for the verdict slot: every check is a table
//   lookup or a compare in the one combinational stage between input and output registers.
// Reset (rst, synchronous): clears the profile to ascii only, the label state
//   and both valid flags.
// Stall: a pending verdict holds in the output register; characters that
//   carry no verdict keep flowing. Only a character with last_in_label waits
//   in the input register until the verdict slot frees, and then items.ready
//   drops for as long as it waits.
module idn_label_script_safety_check import idnsc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  idnsc_cfg_if.sink       cfg,
  idnsc_item_if.sink      items,
  idnsc_verdict_if.source verdicts
);

  // Configuration
  logic [PROF_W-1:0] profile;

  // Input register
  logic  stage_vld;
  item_t stage;
  item_t item_in;

  // Label state
  logic [REASON_W-1:0] fail_code;
  logic                last_script_valid;
  logic [SCRIPT_W-1:0] last_script;
  logic                combo_valid;
  logic [COMBO_W-1:0]  combo_state;
  logic [CP_W-1:0]     saved_zero_digit;
  logic [CP_W-1:0]     previous_code_point;
  logic [HAN_W-1:0]    saved_han;

  // Output register
  logic                out_vld;
  logic                out_safe;
  logic [REASON_W-1:0] out_reason;

  // Effective state seen by the character in the input register
  logic [REASON_W-1:0] e_fail;
  logic                e_lsv;
  logic [SCRIPT_W-1:0] e_ls;
  logic                e_cv;
  logic [COMBO_W-1:0]  e_cs;
  logic [CP_W-1:0]     e_zero;
  logic [CP_W-1:0]     e_prev;
  logic [HAN_W-1:0]    e_han;

  logic                advance;
  logic                load_out;
  logic                prof_ascii;
  logic                xid_bad;
  logic                script_new;
  logic [COMBO_W-1:0]  col;
  logic [COMBO_W-1:0]  combo_nx;
  logic                combo_bad;
  logic [CP_W-1:0]     zero_cp;
  logic                dig_bad;
  logic                nsm_bad;
  logic                han_known;
  logic                han_bad;
  logic [REASON_W-1:0] check_reason;
  logic [REASON_W-1:0] fail_next;
  logic                pass;

  assign cfg.ready = 1'b1;

  always_comb begin
    item_in.code_point         = items.code_point;
    item_in.script_code        = items.script_code;
    item_in.script_group       = items.script_group;
    item_in.xid_class          = items.xid_class;
    item_in.exempt_script      = items.exempt_script;
    item_in.is_decimal_digit   = items.is_decimal_digit;
    item_in.digit_value        = items.digit_value;
    item_in.is_nonspacing_mark = items.is_nonspacing_mark;
    item_in.han_variant        = items.han_variant;
    item_in.first_in_label     = items.first_in_label;
    item_in.last_in_label      = items.last_in_label;
  end

  // Only a verdict-bearing character needs the output slot
  assign advance  = stage_vld && (!stage.last_in_label || !out_vld || verdicts.ready);
  assign load_out = advance && stage.last_in_label;
  assign items.ready = !stage_vld || advance;

  // A first character sees cleared label state
  always_comb begin
    if (stage.first_in_label) begin
      e_fail = FAIL_NONE;
      e_lsv  = 1'b0;
      e_ls   = '0;
      e_cv   = 1'b0;
      e_cs   = '0;
      e_zero = '0;
      e_prev = '0;
      e_han  = HAN_NONE;
    end else begin
      e_fail = fail_code;
      e_lsv  = last_script_valid;
      e_ls   = last_script;
      e_cv   = combo_valid;
      e_cs   = combo_state;
      e_zero = saved_zero_digit;
      e_prev = previous_code_point;
      e_han  = saved_han;
    end
  end

  // Character checks
  always_comb begin
    prof_ascii = (profile == PROF_ASCII) || (profile == PROF_RESERVED);
    xid_bad    = (stage.xid_class != XID_RECOMMENDED) &&
                 !((stage.xid_class == XID_LIMITED) && stage.exempt_script);

    // Common and inherited characters, and repeats of the last script, skip
    // the combination step
    script_new = (stage.script_group != GRP_COMMON) &&
                 (stage.script_group != GRP_INHERITED) &&
                 !(e_lsv && (stage.script_code == e_ls));
    col        = (stage.script_group <= GRP_LATIN) ? stage.script_group : COL_OTHER;
    combo_nx   = e_cv ? combo_step(e_cs, col) : col;
    combo_bad  = script_new && e_cv &&
                 ((combo_nx == ST_FAIL) || ((combo_nx == ST_OTHER) && (profile == PROF_HIGH)));

    // Zero of the digit's numbering system; zero saved means none yet
    zero_cp = stage.code_point - {{(CP_W-DIGIT_W){1'b0}}, stage.digit_value};
    dig_bad = stage.is_decimal_digit && (e_zero != '0) && (zero_cp != e_zero);

    nsm_bad = (e_prev != '0) && (e_prev == stage.code_point) && stage.is_nonspacing_mark;

    han_known = (stage.han_variant == HAN_SIMPLIFIED) ||
                (stage.han_variant == HAN_TRADITIONAL);
    han_bad   = han_known && (e_han != HAN_NONE) && (stage.han_variant != e_han);

    if (prof_ascii) begin
      check_reason = FAIL_ASCII;
    end else if (xid_bad) begin
      check_reason = FAIL_XID;
    end else if (combo_bad) begin
      check_reason = FAIL_SCRIPT;
    end else if (dig_bad) begin
      check_reason = FAIL_NUMBERS;
    end else if (nsm_bad) begin
      check_reason = FAIL_MARK;
    end else if (han_bad) begin
      check_reason = FAIL_HAN;
    end else begin
      check_reason = FAIL_NONE;
    end

    // Latch the first failure; later characters of the label are ignored
    fail_next = (e_fail != FAIL_NONE) ? e_fail : check_reason;
    pass      = (e_fail == FAIL_NONE) && (check_reason == FAIL_NONE);
  end

  // Profile register
  always_ff @(posedge clk) begin
    if (rst) begin
      profile <= PROF_ASCII;
    end else if (cfg.valid) begin
      profile <= cfg.profile_sel;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= 1'b0;
    end else if (items.ready) begin
      stage_vld <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      stage <= item_in;
    end
  end

  // Label state: on a pass take the updates, otherwise keep the effective
  // values so a first character still clears
  always_ff @(posedge clk) begin
    if (rst) begin
      fail_code           <= FAIL_NONE;
      last_script_valid   <= 1'b0;
      last_script         <= '0;
      combo_valid         <= 1'b0;
      combo_state         <= '0;
      saved_zero_digit    <= '0;
      previous_code_point <= '0;
      saved_han           <= HAN_NONE;
    end else if (advance) begin
      fail_code           <= fail_next;
      last_script_valid   <= e_lsv;
      last_script         <= e_ls;
      combo_valid         <= e_cv;
      combo_state         <= e_cs;
      saved_zero_digit    <= e_zero;
      previous_code_point <= e_prev;
      saved_han           <= e_han;
      if (pass) begin
        if (script_new) begin
          last_script_valid <= 1'b1;
          last_script       <= stage.script_code;
          combo_valid       <= 1'b1;
          combo_state       <= combo_nx;
        end
        if (stage.is_decimal_digit && (e_zero == '0)) begin
          saved_zero_digit <= zero_cp;
        end
        if (han_known && (e_han == HAN_NONE)) begin
          saved_han <= stage.han_variant;
        end
        previous_code_point <= stage.code_point;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (load_out) begin
      out_vld <= 1'b1;
    end else if (verdicts.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_safe   <= (fail_next == FAIL_NONE);
      out_reason <= fail_next;
    end
  end

  assign verdicts.valid       = out_vld;
  assign verdicts.label_safe  = out_safe;
  assign verdicts.fail_reason = out_reason;

  // A latched failure survives every later character of its label
  a_fail_sticky : assert property (@(posedge clk) disable iff (rst)
    (advance && !stage.first_in_label && (fail_code != FAIL_NONE))
      |=> (fail_code == $past(fail_code)))
    else $error("latched failure changed within a label");

  // A verdict-bearing character always lands in the output register
  a_verdict_loaded : assert property (@(posedge clk) disable iff (rst)
    load_out |=> (out_vld && (out_reason == $past(fail_next))))
    else $error("verdict not loaded");

  // A character held in the input register is never dropped
  a_stage_held : assert property (@(posedge clk) disable iff (rst)
    (stage_vld && !advance) |=> (stage_vld && $stable(stage)))
    else $error("pending character lost");

endmodule
